### sv/mmdp_pkg.sv
// Package for the masked minimum-distance position block: sizes, codes and bundle types.
package mmdp_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int POS_W = 11;
  localparam int AMOUNT_W = 31;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W = 64;
  localparam int ADDR_W = $clog2(MAX_POSITIONS);
  localparam int FULL_W = $clog2(MAX_POSITIONS + 1);
  // counter width: holds any position field value and the position count itself
  localparam int CNT_W = (POS_W > FULL_W) ? POS_W : FULL_W;
  localparam int PROD_W = CNT_W + 1 + WEIGHT_W;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_AVAIL = 2'd2,
    OP_BLOCK = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_RANGE,
    ST_SETUP,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_e                  op;
    logic [POS_W-1:0]     position;
    logic [AMOUNT_W-1:0]  amount;
    logic [POS_W-1:0]     range_low;
    logic [POS_W-1:0]     range_high;
  } req_t;

  typedef struct packed {
    logic [POS_W-1:0] best_position;
    logic             found;
  } res_t;

  typedef struct packed {
    logic                w_we;
    logic                m_we;
    logic [ADDR_W-1:0]   waddr;
    logic [WEIGHT_W-1:0] wdata;
    logic                mdata;
    logic [ADDR_W-1:0]   raddr;
  } store_req_t;

  typedef struct packed {
    logic             init;
    logic             step;
    logic [CNT_W-1:0] pos;
  } scan_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             found;
    logic [CNT_W-1:0] best_pos;
  } scan_stat_t;

endpackage

### sv/mmdp_store.sv
// Weight and blocked-mask memories, one write and one registered read port each.
module mmdp_store (
  input  logic                                 clk,
  input  mmdp_pkg::store_req_t                 cmd,
  output logic [mmdp_pkg::WEIGHT_W-1:0]        rd_weight,
  output logic                                 rd_blocked
);

  logic [mmdp_pkg::WEIGHT_W-1:0] weight_mem [mmdp_pkg::MAX_POSITIONS];
  logic                          blocked_mem [mmdp_pkg::MAX_POSITIONS];

  always_ff @(posedge clk) begin
    if (cmd.w_we) begin
      weight_mem[cmd.waddr] <= cmd.wdata;
    end
    rd_weight <= weight_mem[cmd.raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.m_we) begin
      blocked_mem[cmd.waddr] <= cmd.mdata;
    end
    rd_blocked <= blocked_mem[cmd.raddr];
  end

endmodule

### sv/mmdp_scan.sv
// Distance accumulator and best-position compare, one position per cycle.
module mmdp_scan (
  input  logic                               clk,
  input  logic                               rst,
  input  mmdp_pkg::scan_ctrl_t               ctrl,
  input  logic [mmdp_pkg::SUM_W-1:0]         moment,
  input  logic [mmdp_pkg::SUM_W-1:0]         total,
  input  logic [mmdp_pkg::WEIGHT_W-1:0]      rd_weight,
  input  logic                               rd_blocked,
  output mmdp_pkg::scan_stat_t               stat
);

  logic                         step_q;
  logic                         cmp_valid;
  logic [mmdp_pkg::CNT_W-1:0]   pos_q1;
  logic [mmdp_pkg::CNT_W-1:0]   pos_q2;
  logic                         blk_q2;
  logic [mmdp_pkg::SUM_W-1:0]   dis;
  logic [mmdp_pkg::SUM_W-1:0]   diff;      // left - right
  logic [mmdp_pkg::SUM_W-1:0]   best_dis;
  logic [mmdp_pkg::CNT_W-1:0]   best_pos;
  logic                         found;
  logic [mmdp_pkg::SUM_W-1:0]   w_twice;
  logic                         better;

  // twice the sign-extended weight
  assign w_twice = {{(mmdp_pkg::SUM_W - mmdp_pkg::WEIGHT_W - 1){rd_weight[mmdp_pkg::WEIGHT_W-1]}},
                    rd_weight, 1'b0};
  assign better = cmp_valid && !blk_q2 && (!found || ($signed(dis) < $signed(best_dis)));

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q    <= 1'b0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      step_q    <= ctrl.step;
      cmp_valid <= step_q;
      if (ctrl.init) begin
        found <= 1'b0;
      end else if (better) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_q1 <= ctrl.pos;
    if (ctrl.init) begin
      dis      <= moment;
      diff     <= '0 - total;
      best_pos <= '0;
      best_dis <= '0;
    end else begin
      if (step_q) begin
        dis    <= dis + diff;
        diff   <= diff + w_twice;
        pos_q2 <= pos_q1;
        blk_q2 <= rd_blocked;
      end
      if (better) begin
        best_pos <= pos_q2;
        best_dis <= dis;
      end
    end
  end

  assign stat.busy     = step_q | cmp_valid;
  assign stat.found    = found;
  assign stat.best_pos = best_pos;

endmodule

### sv/masked_min_distance_position.sv
// Top level of the masked minimum-distance position block.
// Holds a signed 32-bit weight per position 1..1024 and an availability mask. Each request
// either adds or subtracts weight at one position, or marks a range available or unavailable;
// the block then walks positions 1..positions_in_use once and returns the first available
// position with the least total weighted distance (signed 64-bit, ties keep the lower
// position), or found = 0 with position 0 when every scanned position is blocked.
// After reset a clearing pass zeroes both memories, during which req_stall is high
// (configuration writes still land). The scan walks the read ports one position per cycle
// and the range marking walks the mask write port one position per cycle. One request is
// in flight at a time; a finished result sits in the output register so the next request
// can be taken.
module masked_min_distance_position (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  mmdp_pkg::req_t                    req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output mmdp_pkg::res_t                    res,
  input  logic                              cfg_we,
  input  logic [mmdp_pkg::POS_W-1:0]        cfg_data
);

  localparam logic [mmdp_pkg::CNT_W-1:0] CNT_ONE = mmdp_pkg::CNT_W'(1);
  localparam logic [mmdp_pkg::CNT_W-1:0] CNT_MAX = mmdp_pkg::CNT_W'(mmdp_pkg::MAX_POSITIONS);

  mmdp_pkg::state_t               state, state_next;
  logic [mmdp_pkg::CNT_W-1:0]     ptr, ptr_next;
  logic [mmdp_pkg::CNT_W-1:0]     limit;
  mmdp_pkg::req_t                 req_q;
  logic [mmdp_pkg::WEIGHT_W-1:0]  val;
  logic signed [mmdp_pkg::PROD_W-1:0] prod;
  logic [mmdp_pkg::SUM_W-1:0]     total;
  logic [mmdp_pkg::SUM_W-1:0]     moment;

  mmdp_pkg::store_req_t           st_cmd;
  mmdp_pkg::scan_ctrl_t           sc_ctrl;
  mmdp_pkg::scan_stat_t           sc_stat;
  logic [mmdp_pkg::WEIGHT_W-1:0]  rd_weight;
  logic                           rd_blocked;

  logic                           accept;
  logic                           load_res;
  logic [mmdp_pkg::CNT_W-1:0]     in_pos, in_lo, in_hi;
  logic [mmdp_pkg::CNT_W-1:0]     q_pos, q_hi;
  logic                           in_pos_ok;
  logic [mmdp_pkg::CNT_W-1:0]     cfg_ext;
  logic [mmdp_pkg::WEIGHT_W-1:0]  in_val;

  // ---- request decode: clamp the range, check the weight position
  assign in_pos    = mmdp_pkg::CNT_W'(req.position);
  assign in_lo     = (req.range_low == '0) ? CNT_ONE : mmdp_pkg::CNT_W'(req.range_low);
  assign in_hi     = (mmdp_pkg::CNT_W'(req.range_high) > CNT_MAX) ? CNT_MAX
                                                                   : mmdp_pkg::CNT_W'(req.range_high);
  assign in_pos_ok = (in_pos != '0) && (in_pos <= CNT_MAX);
  assign in_val    = (req.op == mmdp_pkg::OP_SUB) ? ('0 - {1'b0, req.amount}) : {1'b0, req.amount};

  assign q_pos = mmdp_pkg::CNT_W'(req_q.position);
  assign q_hi  = (mmdp_pkg::CNT_W'(req_q.range_high) > CNT_MAX) ? CNT_MAX
                                                                 : mmdp_pkg::CNT_W'(req_q.range_high);

  // register write clamps to 1..MAX_POSITIONS
  assign cfg_ext = (mmdp_pkg::CNT_W'(cfg_data) == '0) ? CNT_ONE :
                   (mmdp_pkg::CNT_W'(cfg_data) > CNT_MAX) ? CNT_MAX : mmdp_pkg::CNT_W'(cfg_data);

  assign req_stall = (state != mmdp_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign load_res  = (state == mmdp_pkg::ST_DONE) && (!res_valid || !res_stall);

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmdp_pkg::ST_CLEAR;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_comb begin
    state_next   = state;
    ptr_next     = ptr;
    st_cmd       = '0;
    sc_ctrl      = '0;
    sc_ctrl.pos  = ptr + CNT_ONE;
    unique case (state)
      mmdp_pkg::ST_CLEAR: begin
        // zero both memories, one entry a cycle
        st_cmd.w_we  = 1'b1;
        st_cmd.m_we  = 1'b1;
        st_cmd.waddr = ptr[mmdp_pkg::ADDR_W-1:0];
        if (ptr == CNT_MAX - CNT_ONE) begin
          state_next = mmdp_pkg::ST_IDLE;
          ptr_next   = '0;
        end else begin
          ptr_next = ptr + CNT_ONE;
        end
      end
      mmdp_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (req.op)
            mmdp_pkg::OP_ADD, mmdp_pkg::OP_SUB: begin
              state_next = in_pos_ok ? mmdp_pkg::ST_READ : mmdp_pkg::ST_SETUP;
            end
            mmdp_pkg::OP_AVAIL, mmdp_pkg::OP_BLOCK: begin
              if (in_lo <= in_hi) begin
                state_next = mmdp_pkg::ST_RANGE;
                ptr_next   = in_lo - CNT_ONE;
              end else begin
                state_next = mmdp_pkg::ST_SETUP;
              end
            end
            default: state_next = mmdp_pkg::ST_SETUP;
          endcase
        end
      end
      mmdp_pkg::ST_READ: begin
        st_cmd.raddr = mmdp_pkg::ADDR_W'(q_pos - CNT_ONE);
        state_next   = mmdp_pkg::ST_WRITE;
      end
      mmdp_pkg::ST_WRITE: begin
        // read-modify-write of the weight entry
        st_cmd.w_we  = 1'b1;
        st_cmd.waddr = mmdp_pkg::ADDR_W'(q_pos - CNT_ONE);
        st_cmd.wdata = rd_weight + val;
        state_next   = mmdp_pkg::ST_SETUP;
      end
      mmdp_pkg::ST_RANGE: begin
        st_cmd.m_we  = 1'b1;
        st_cmd.waddr = ptr[mmdp_pkg::ADDR_W-1:0];
        st_cmd.mdata = (req_q.op == mmdp_pkg::OP_BLOCK);
        if (ptr == q_hi - CNT_ONE) begin
          state_next = mmdp_pkg::ST_SETUP;
        end else begin
          ptr_next = ptr + CNT_ONE;
        end
      end
      mmdp_pkg::ST_SETUP: begin
        sc_ctrl.init = 1'b1;
        ptr_next     = '0;
        state_next   = mmdp_pkg::ST_SCAN;
      end
      mmdp_pkg::ST_SCAN: begin
        st_cmd.raddr = ptr[mmdp_pkg::ADDR_W-1:0];
        sc_ctrl.step = 1'b1;
        if (ptr + CNT_ONE == limit) begin
          state_next = mmdp_pkg::ST_DRAIN;
        end else begin
          ptr_next = ptr + CNT_ONE;
        end
      end
      mmdp_pkg::ST_DRAIN: begin
        if (!sc_stat.busy) begin
          state_next = mmdp_pkg::ST_DONE;
        end
      end
      mmdp_pkg::ST_DONE: begin
        if (load_res) begin
          state_next = mmdp_pkg::ST_IDLE;
        end
      end
      default: state_next = mmdp_pkg::ST_IDLE;
    endcase
  end

  // ---- request capture, running totals, position count register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      val   <= in_val;
    end
    if (state == mmdp_pkg::ST_READ) begin
      prod <= $signed({1'b0, q_pos}) * $signed(val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      moment <= '0;
      limit  <= CNT_MAX;
    end else begin
      if (state == mmdp_pkg::ST_WRITE) begin
        total  <= total + {{(mmdp_pkg::SUM_W - mmdp_pkg::WEIGHT_W){val[mmdp_pkg::WEIGHT_W-1]}}, val};
        moment <= moment + {{(mmdp_pkg::SUM_W - mmdp_pkg::PROD_W){prod[mmdp_pkg::PROD_W-1]}}, prod};
      end
      if (cfg_we) begin
        limit <= cfg_ext;
      end
    end
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res.best_position <= sc_stat.found ? mmdp_pkg::POS_W'(sc_stat.best_pos) : '0;
      res.found         <= sc_stat.found;
    end
  end

  mmdp_store u_store (
    .clk        (clk),
    .cmd        (st_cmd),
    .rd_weight  (rd_weight),
    .rd_blocked (rd_blocked)
  );

  mmdp_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sc_ctrl),
    .moment     (moment),
    .total      (total),
    .rd_weight  (rd_weight),
    .rd_blocked (rd_blocked),
    .stat       (sc_stat)
  );

endmodule

### tb/sv/tb_masked_min_distance_position.sv
// Self-checking testbench for the masked minimum-distance position block.
module tb_masked_min_distance_position;
  timeunit 1ns;
  timeprecision 1ps;

  import mmdp_pkg::*;

  // Largest value an 11-bit position field can carry.
  localparam int unsigned FIELD_MAX = (1 << POS_W) - 1;
  // Worst correct run is roughly 320 requests, each a full range walk plus a full scan,
  // plus the clearing pass; this allows several times that.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // Settle time after the last result: one full range walk plus one full scan.
  localparam int unsigned END_SETTLE = 2 * MAX_POSITIONS + 16;
  localparam int NUM_PHASES = 9;

  logic clk;
  logic rst = 1'b1;

  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_bus = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res_bus;
  logic cfg_we = 1'b0;
  logic [POS_W-1:0] cfg_data = '0;

  masked_min_distance_position uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_bus),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res_bus),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the weights, the blocked mask, the running
  // totals and the scan length. Two-state types so everything starts at zero,
  // matching the block after reset.
  // ---------------------------------------------------------------------------
  bit [WEIGHT_W-1:0] weight_mem [1:MAX_POSITIONS];
  bit                blocked    [1:MAX_POSITIONS];
  bit [SUM_W-1:0]    weight_total;
  bit [SUM_W-1:0]    moment_total;
  int unsigned       scan_len = MAX_POSITIONS;

  req_t pending_reqs[$];       // requests waiting for the driver
  res_t expected_results[$];   // predicted answers, oldest first

  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned none_free_seen;
  int unsigned configs_written;
  int unsigned mismatches;
  int unsigned cycle_count;

  bit tx_eager;   // sender runs back to back while set
  bit rx_eager;   // receiver never stalls while set
  int unsigned tx_gap;
  int unsigned rx_wait;

  // Apply one request to the predictor state, then walk positions 1..scan_len.
  // D(p) is carried incrementally: moving from p-1 to p adds the weight to the
  // left and removes the weight to the right. Signed 64-bit compare, strict,
  // so ties keep the lowest free position.
  function automatic res_t apply_and_locate(req_t r);
    bit [SUM_W-1:0] delta, left_w, right_w, run_dist, best_dist, w_ext;
    int unsigned lo, hi, p;
    res_t out;
    out = '0;
    best_dist = '0;
    if (r.op == OP_ADD || r.op == OP_SUB) begin
      // out-of-range positions leave everything untouched
      if (r.position >= 1 && r.position <= MAX_POSITIONS) begin
        delta = (r.op == OP_SUB) ? -64'(r.amount) : 64'(r.amount);
        weight_mem[r.position] += delta[WEIGHT_W-1:0];
        weight_total += delta;
        moment_total += 64'(r.position) * delta;
      end
    end else begin
      lo = (r.range_low < 1) ? 1 : r.range_low;
      hi = (r.range_high > MAX_POSITIONS) ? MAX_POSITIONS : r.range_high;
      for (p = lo; p <= hi; p++) blocked[p] = (r.op == OP_BLOCK);
    end
    left_w = '0;
    right_w = weight_total;
    run_dist = moment_total;
    for (p = 1; p <= scan_len; p++) begin
      w_ext = {{(SUM_W-WEIGHT_W){weight_mem[p][WEIGHT_W-1]}}, weight_mem[p]};
      run_dist = run_dist + left_w - right_w;
      left_w += w_ext;
      right_w -= w_ext;
      if (!blocked[p] && (!out.found || $signed(run_dist) < $signed(best_dist))) begin
        out.found = 1'b1;
        out.best_position = POS_W'(p);
        best_dist = run_dist;
      end
    end
    return out;
  endfunction

  // Queue one request. Fields the op does not use carry random noise so that
  // the block is seen to ignore them.
  function automatic void queue_req(op_e op, int unsigned pos, int unsigned amt,
                                    int unsigned lo, int unsigned hi);
    req_t r;
    r.op = op;
    r.position = POS_W'(pos);
    r.amount = AMOUNT_W'(amt);
    r.range_low = POS_W'(lo);
    r.range_high = POS_W'(hi);
    if (op == OP_ADD || op == OP_SUB) begin
      r.range_low = POS_W'($urandom);
      r.range_high = POS_W'($urandom);
    end else begin
      r.position = POS_W'($urandom);
      r.amount = AMOUNT_W'($urandom);
    end
    pending_reqs.push_back(r);
  endfunction

  // Random request: weights mostly land inside the scanned window and ranges are
  // mostly short, so the scan result moves about; a share of wild fields, empty
  // ranges and whole-store ranges is mixed in.
  function automatic void queue_random_req();
    int unsigned sel, pos, amt, lo, hi;
    op_e op;
    sel = $urandom_range(0, 99);
    if (sel < 35) op = OP_ADD;
    else if (sel < 60) op = OP_SUB;
    else if (sel < 80) op = OP_AVAIL;
    else op = OP_BLOCK;
    case ($urandom_range(0, 9))
      8: pos = $urandom_range(1, MAX_POSITIONS);
      9: pos = $urandom_range(0, FIELD_MAX);
      default: pos = $urandom_range(1, scan_len);
    endcase
    case ($urandom_range(0, 9))
      5, 6, 7: amt = $urandom & 32'h7FFF_FFFF;
      8: amt = 32'h7FFF_FFFF;
      9: amt = 1 << $urandom_range(0, AMOUNT_W - 1);
      default: amt = $urandom_range(0, 1000);
    endcase
    lo = $urandom_range(1, scan_len);
    case ($urandom_range(0, 9))
      7: begin
        lo = $urandom_range(0, FIELD_MAX);
        hi = $urandom_range(0, FIELD_MAX);
      end
      8: hi = lo - 1;
      9: begin
        lo = $urandom_range(0, 1);
        hi = $urandom_range(0, 1) ? scan_len : FIELD_MAX;
      end
      default: hi = lo + $urandom_range(0, 16);
    endcase
    queue_req(op, pos, amt, lo, hi);
  endfunction

  // Block is idle once nothing is queued, nothing offered and nothing owed.
  // Sampled on the falling edge so every update of the rising edge has settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_valid || expected_results.size() != 0);
  endtask

  // Write positions_in_use; the predictor holds the clamped value.
  task automatic set_positions(int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= POS_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_len = (v == 0) ? 1 : (v > MAX_POSITIONS) ? MAX_POSITIONS : v;
    configs_written++;
    @(negedge clk);
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_count, expected_results.size());
      $display("tb_masked_min_distance_position: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: offers queued requests, predicts each one as it is taken,
  // then idles for a randomly drawn gap before the next. Runs of back-to-back requests
  // come from the eager flag, which flips now and then.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : request_driver
    logic free;
    if (rst) begin
      req_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      free = !req_valid || !req_stall;
      if (req_valid && !req_stall) begin
        expected_results.push_back(apply_and_locate(req_bus));
        requests_sent++;
      end
      if (free) begin
        if (tx_gap != 0) begin
          tx_gap = tx_gap - 1;
          req_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_bus <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          if ($urandom_range(0, 15) == 0) tx_eager = !tx_eager;
          tx_gap = tx_eager ? 0 : $urandom_range(0, 6);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: each result may be held off by a random stall once it shows,
  // then checked field by field against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    res_t want;
    if (rst) begin
      res_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: best_position %0d found %0b",
                     res_bus.best_position, res_bus.found);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (!res_bus.found) none_free_seen++;
          if (res_bus.best_position !== want.best_position || res_bus.found !== want.found) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected position %0d found %0b, got position %0d found %0b",
                       results_checked, want.best_position, want.found,
                       res_bus.best_position, res_bus.found);
          end
        end
        if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
        rx_wait = rx_eager ? 0 : $urandom_range(0, 6);
      end else if (res_valid && rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end
      res_stall <= (rx_wait != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening at the reset scan length, then random phases,
  // each under its own positions_in_use. The register only changes with the
  // block idle, which also makes the sender wait for every result.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned settings [NUM_PHASES];
    int unsigned sizes [NUM_PHASES];
    int ph, n;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero weights: every distance ties, so the first free position wins
    queue_req(OP_AVAIL, 0, 0, 1, MAX_POSITIONS);
    queue_req(OP_BLOCK, 0, 0, 1, 3);
    // extreme weights at both ends
    queue_req(OP_ADD, 1, 32'h7FFF_FFFF, 0, 0);
    queue_req(OP_ADD, MAX_POSITIONS, 32'h7FFF_FFFF, 0, 0);
    // positions outside the store change nothing
    queue_req(OP_ADD, 0, 5, 0, 0);
    queue_req(OP_ADD, MAX_POSITIONS + 1, 9, 0, 0);
    queue_req(OP_SUB, FIELD_MAX, 32'h7FFF_FFFF, 0, 0);
    // two full subtractions wrap the 32-bit weight
    queue_req(OP_SUB, 512, 32'h7FFF_FFFF, 0, 0);
    queue_req(OP_SUB, 512, 32'h7FFF_FFFF, 0, 0);
    queue_req(OP_SUB, 512, 3, 0, 0);
    queue_req(OP_ADD, 700, 0, 0, 0);
    // everything blocked, range bounds clipped both sides
    queue_req(OP_BLOCK, 0, 0, 0, FIELD_MAX);
    queue_req(OP_AVAIL, 0, 0, MAX_POSITIONS, MAX_POSITIONS);
    // empty ranges: low above high, and low clipped to one above high of zero
    queue_req(OP_AVAIL, 0, 0, 5, 4);
    queue_req(OP_AVAIL, 0, 0, 0, 0);
    queue_req(OP_AVAIL, 0, 0, 1, 1);
    queue_req(OP_BLOCK, 0, 0, 1, 1);
    queue_req(OP_AVAIL, 0, 0, 300, 700);
    // negative weight pulls distances below zero
    queue_req(OP_SUB, 2, 32'h4000_0000, 0, 0);
    queue_req(OP_ADD, MAX_POSITIONS - 1, 1, 0, 0);
    queue_req(OP_AVAIL, 0, 0, 1, FIELD_MAX);
    queue_req(OP_ADD, 600, 12345, 0, 0);
    queue_req(OP_ADD, 601, 12345, 0, 0);
    wait_idle();

    // register extremes, including values held as 1 and as the maximum
    settings = '{0, FIELD_MAX, 1, 2, $urandom_range(3, 64), MAX_POSITIONS + 1,
                 $urandom_range(1, MAX_POSITIONS), MAX_POSITIONS - 1, MAX_POSITIONS};
    sizes = '{20, 40, 20, 20, 40, 40, 40, 30, 40};
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_positions(settings[ph]);
      for (n = 0; n < sizes[ph]; n++) queue_random_req();
      wait_idle();
    end

    repeat (END_SETTLE) @(posedge clk);

    $display("covered %0d requests under %0d scan lengths (1 up to %0d, clamped writes too)",
             requests_sent, configs_written, MAX_POSITIONS);
    $display("checked %0d results, %0d with every scanned position blocked; %0d mismatches",
             results_checked, none_free_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_masked_min_distance_position: done, clean");
    end else begin
      $display("tb_masked_min_distance_position: done, errors");
    end
    $finish;
  end

endmodule

### masked_min_distance_position.f
sv/mmdp_pkg.sv
sv/mmdp_store.sv
sv/mmdp_scan.sv
sv/masked_min_distance_position.sv
tb/sv/tb_masked_min_distance_position.sv
